>>> rtl/core/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Sizes of the queue, the result and mode codes, and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned MAX_RESULTS = 8;

  localparam int unsigned TICK_W   = 64;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned TMO_W    = 32;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KIND_W   = 3;

  // Slot index and fill count; the count must also hold SLOTS itself.
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STARTED   = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_EXPIRED   = 3'd2,
    KIND_NONE_DUE  = 3'd3,
    KIND_STOPPED   = 3'd4,
    KIND_NOT_FOUND = 3'd5,
    KIND_CLEARED   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_POP,
    S_DIV,
    S_ADD,
    S_SCAN,
    S_INS,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/stq_div.sv
// ----------------------------------------------------------------------------
// stq_div: serial unsigned divider
// Restoring division of the timeout by the tick period, one quotient bit per
// cycle. done_o pulses for one cycle when quotient_o is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [stq_pkg::TMO_W-1:0]     dividend_i,
  input  wire logic [stq_pkg::PERIOD_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic [stq_pkg::TMO_W-1:0]          quotient_o
);
  import stq_pkg::*;

  localparam int unsigned STEP_W = $clog2(TMO_W);

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [PERIOD_W-1:0] dvs_q;
  logic [TMO_W-1:0]    quo_q;

  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W:0]   rem_sub;
  logic                ge;

  // The remainder stays below the divisor, so it fits in PERIOD_W bits.
  assign rem_sh  = {rem_q, quo_q[TMO_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(TMO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      quo_q <= {quo_q[TMO_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/sorted_software_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_software_timer_queue_unit: one-shot timers kept in deadline order
// Start, stop, clear and tick items on a sorted queue of SLOTS entries, with
// a serial divider turning timeouts in ms into ticks.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | in_valid / in_ready  | mode, delay_ms, stop_id
//  result   | out       | out_valid / out_ready| result_kind, tmr_id, last
//  config   | in        | cfg_we, no wait      | cfg_wdata (tick period in ms)
//
// A start item holds the input through the serial divider, the deadline add,
// a scan past the entries that sort ahead of it, the insert and the loading
// of the result. A refused start and a clear go straight to their result. A
// tick advances the tick count and then gives one result per due entry, or a
// none-due result, and a stop scans the entries for its id before its result.
// Reset empties the queue at once; a stalled result only holds back the
// sequencer when it has a new result to present.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_software_timer_queue_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [stq_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [stq_pkg::TMO_W-1:0]     delay_ms_i,
  input  wire logic [stq_pkg::ID_W-1:0]      stop_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [stq_pkg::KIND_W-1:0]         result_kind_o,
  output logic [stq_pkg::ID_W-1:0]           tmr_id_o,
  output logic                               last_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [stq_pkg::PERIOD_W-1:0]  cfg_wdata_i
);
  import stq_pkg::*;

  localparam int unsigned NXT = (SLOTS > 1) ? 1 : 0;

  state_e              state_q, state_d;
  logic [PERIOD_W-1:0] period_q;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [ID_W-1:0]     idc_q, idc_d;
  logic [CNT_W-1:0]    len_q, len_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [RES_W-1:0]    npop_q, npop_d;
  logic [MODE_W-1:0]   mode_q;
  logic [ID_W-1:0]     sid_q;
  logic [TICK_W-1:0]   dl_q, dl_d;
  kind_e               pend_kind_q, pend_kind_d;
  logic [ID_W-1:0]     pend_id_q, pend_id_d;

  entry_t              entry_q [SLOTS];

  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [ID_W-1:0]     out_id_q;
  logic                out_last_q;
  logic                out_free;
  logic                out_load;
  kind_e               out_kind;
  logic [ID_W-1:0]     out_id;
  logic                out_last;

  logic                ins_en;
  logic                rem_en;
  logic [IDX_W-1:0]    pos;
  entry_t              new_entry;

  logic                in_acc;
  logic                div_start;
  logic                div_done;
  logic [TMO_W-1:0]    div_quo;
  logic [PERIOD_W-1:0] divisor;
  logic [TICK_W:0]     dl_sum;
  logic [ID_W-1:0]     id_inc;
  entry_t              scan_entry;
  logic                head_due;
  logic                next_due;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // A period of zero divides as if it were one.
  assign divisor = (period_q == '0) ? PERIOD_W'(1) : period_q;

  // The divider loads its dividend on the accepting edge itself.
  stq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (delay_ms_i),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign dl_sum     = {1'b0, tick_q} + {{(TICK_W + 1 - TMO_W){1'b0}}, div_quo};
  assign id_inc     = idc_q + ID_W'(1);
  assign scan_entry = entry_q[idx_q[IDX_W-1:0]];
  assign head_due   = (len_q != '0) && (entry_q[0].deadline <= tick_q);
  assign next_due   = (len_q > CNT_W'(1)) && (entry_q[NXT].deadline <= tick_q);

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    idc_d       = idc_q;
    len_d       = len_q;
    idx_d       = idx_q;
    npop_d      = npop_q;
    dl_d        = dl_q;
    pend_kind_d = pend_kind_q;
    pend_id_d   = pend_id_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_kind    = KIND_NONE_DUE;
    out_id      = '0;
    out_last    = 1'b1;
    ins_en      = 1'b0;
    rem_en      = 1'b0;
    pos         = idx_q[IDX_W-1:0];
    new_entry   = '{deadline: dl_q, id: idc_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d  = '0;
          npop_d = '0;
          unique case (mode_e'(mode_i))
            MODE_TICK: state_d = S_TICK;
            MODE_START: begin
              if (len_q >= CNT_W'(SLOTS)) begin
                pend_kind_d = KIND_FULL;
                pend_id_d   = '0;
                state_d     = S_EMIT;
              end else begin
                state_d = S_DIV;
              end
            end
            MODE_STOP: state_d = S_SCAN;
            MODE_CLEAR: begin
              len_d       = '0;
              pend_kind_d = KIND_CLEARED;
              pend_id_d   = '0;
              state_d     = S_EMIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_TICK: begin
        tick_d  = tick_q + TICK_W'(1);
        state_d = S_POP;
      end

      S_POP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (head_due) begin
            // Look ahead at the next entry so the last flag rides on this item.
            out_kind = KIND_EXPIRED;
            out_id   = entry_q[0].id;
            out_last = !(next_due && (npop_q != RES_W'(MAX_RESULTS - 1)));
            rem_en   = 1'b1;
            pos      = '0;
            len_d    = len_q - CNT_W'(1);
            npop_d   = npop_q + RES_W'(1);
            if (out_last) begin
              state_d = S_IDLE;
            end
          end else begin
            out_kind = KIND_NONE_DUE;
            state_d  = S_IDLE;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          state_d = S_ADD;
        end
      end

      S_ADD: begin
        // The deadline saturates instead of wrapping.
        dl_d    = dl_sum[TICK_W] ? {TICK_W{1'b1}} : dl_sum[TICK_W-1:0];
        state_d = S_SCAN;
      end

      S_SCAN: begin
        if (mode_q == MODE_STOP) begin
          if (idx_q < len_q) begin
            if (scan_entry.id == sid_q) begin
              rem_en      = 1'b1;
              len_d       = len_q - CNT_W'(1);
              pend_kind_d = KIND_STOPPED;
              pend_id_d   = sid_q;
              state_d     = S_EMIT;
            end else begin
              idx_d = idx_q + CNT_W'(1);
            end
          end else begin
            pend_kind_d = KIND_NOT_FOUND;
            pend_id_d   = '0;
            state_d     = S_EMIT;
          end
        end else begin
          if ((idx_q < len_q) && (scan_entry.deadline < dl_q)) begin
            idx_d = idx_q + CNT_W'(1);
          end else begin
            idc_d   = (id_inc == '0) ? ID_W'(1) : id_inc;
            state_d = S_INS;
          end
        end
      end

      S_INS: begin
        ins_en      = 1'b1;
        len_d       = len_q + CNT_W'(1);
        pend_kind_d = KIND_STARTED;
        pend_id_d   = idc_q;
        state_d     = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = pend_kind_q;
          out_id   = pend_id_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    div_start = (state_q == S_IDLE) && in_acc && (mode_e'(mode_i) == MODE_START) &&
                (len_q < CNT_W'(SLOTS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      period_q <= PERIOD_RESET;
      tick_q   <= '0;
      idc_q    <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      npop_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      tick_q <= tick_d;
      idc_q  <= idc_d;
      len_q  <= len_d;
      idx_q  <= idx_d;
      npop_q <= npop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      sid_q  <= stop_id_i;
    end
    dl_q        <= dl_d;
    pend_kind_q <= pend_kind_d;
    pend_id_q   <= pend_id_d;
  end

  // Each slot takes the new entry, its upper or lower neighbor, or holds.
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (ins_en && (IDX_W'(i) == pos)) begin
        entry_q[i] <= new_entry;
      end else if (ins_en && (IDX_W'(i) > pos)) begin
        if (i > 0) begin
          entry_q[i] <= entry_q[(i > 0) ? i - 1 : 0];
        end
      end else if (rem_en && (IDX_W'(i) >= pos)) begin
        if (i < SLOTS - 1) begin
          entry_q[i] <= entry_q[(i < SLOTS - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind;
      out_id_q   <= out_id;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign tmr_id_o      = out_id_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire
